// ----- rtl/tbp_pkg.sv -----
// shared types and constants of the tournament branch predictor
package tbp_pkg;

   localparam int ADDR_W = 32;

   // chooser counters are always two bits, reset to weakly gshare
   localparam int CHO_W = 2;
   localparam logic [CHO_W-1:0] CHO_INIT = 2'd1;
   localparam logic [CHO_W-1:0] CHO_MAX = 2'd3;

   // one resolved branch as it travels from the front queue to the back
   typedef struct packed {
      logic [ADDR_W-1:0] branch_address;
      logic              taken;
   } tbp_item_type;

endpackage

// ----- rtl/tbp_ram.sv -----
// generic single write port ram with registered read
module tbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tbp_front.sv -----
// front end: accepts branch transactions into a two entry queue
module tbp_front
   import tbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [31:0]  req_branch_address,
   input  logic         req_taken,
   output logic         item_valid,
   output tbp_item_type item,
   input  logic         item_pop
);

   tbp_item_type q_ff [2];
   logic [1:0]   cnt_ff, cnt_in;
   logic         rd_ff, rd_in;
   logic         wr_ff, wr_in;
   logic         push;

   assign req_ready  = (cnt_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rd_ff];

   // pointer and fill count
   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      wr_in  = wr_ff;
      if (push) begin
         wr_in = ~wr_ff;
      end
      if (item_pop) begin
         rd_in = ~rd_ff;
      end
      if (push && !item_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && item_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff].branch_address <= req_branch_address;
         q_ff[wr_ff].taken          <= req_taken;
      end
   end

endmodule

// ----- rtl/tbp_back.sv -----
// back end: table read-modify-write sequencer and result register
module tbp_back
   import tbp_pkg::*;
#(
   parameter int PATTERN_INDEX_BITS = 12,
   parameter int HISTORY_BITS       = 2,
   parameter int LOCAL_TABLE_BITS   = 6,
   parameter int COUNTER_BITS       = 2,
   parameter int CHOOSER_INDEX_BITS = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  tbp_item_type item,
   output logic         item_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_predicted_taken,
   output logic         rsp_chose_local,
   output logic         rsp_prediction_correct
);

   localparam int P  = PATTERN_INDEX_BITS;
   localparam int H  = HISTORY_BITS;
   localparam int L  = LOCAL_TABLE_BITS;
   localparam int CB = COUNTER_BITS;
   localparam int C  = CHOOSER_INDEX_BITS;
   localparam int SW = (P > C) ? ((P > L) ? P : L) : ((C > L) ? C : L);
   localparam logic [CB-1:0] CNT_INIT = CB'((1 << (CB - 1)) - 1);
   localparam logic [CB-1:0] CNT_MAX  = {CB{1'b1}};

   localparam logic [2:0] ST_SWEEP = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HIST  = 3'd2;
   localparam logic [2:0] ST_LCNT  = 3'd3;
   localparam logic [2:0] ST_UPD   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [SW-1:0]     sweep_ff, sweep_in;
   logic [ADDR_W-1:0] addr_ff;
   logic              taken_ff;
   logic [H-1:0]      ghist_ff, ghist_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              pred_ff, local_ff, corr_ff;

   logic [P-1:0]      gsh_idx, lc_idx;
   logic [L-1:0]      lh_idx;
   logic [C-1:0]      cho_idx;
   logic [CB-1:0]     gsh_rd, lc_rd, gsh_new, lc_new;
   logic [H-1:0]      lh_rd, lh_new;
   logic [CHO_W-1:0]  cho_rd, cho_new;
   logic              pg, pl, use_local, pred, upd_go, sweeping;

   // table indexes from the held branch
   assign gsh_idx = addr_ff[P-1:0] ^ P'({{ADDR_W{1'b0}}, ghist_ff});
   assign lc_idx  = addr_ff[P-1:0] ^ P'({{ADDR_W{1'b0}}, lh_rd});
   assign lh_idx  = addr_ff[L-1:0];
   assign cho_idx = addr_ff[C-1:0];

   // component predictions and chooser decision
   assign pg        = gsh_rd[CB-1];
   assign pl        = lc_rd[CB-1];
   assign use_local = cho_rd[CHO_W-1];
   assign pred      = use_local ? pl : pg;

   // saturating training
   always_comb begin
      gsh_new = gsh_rd;
      lc_new  = lc_rd;
      cho_new = cho_rd;
      if (taken_ff) begin
         if (gsh_rd != CNT_MAX) gsh_new = gsh_rd + CB'(1);
         if (lc_rd != CNT_MAX) lc_new = lc_rd + CB'(1);
      end else begin
         if (gsh_rd != '0) gsh_new = gsh_rd - CB'(1);
         if (lc_rd != '0) lc_new = lc_rd - CB'(1);
      end
      if (pg == taken_ff && pl != taken_ff) begin
         if (cho_rd != '0) cho_new = cho_rd - CHO_W'(1);
      end else begin
         if (cho_rd != CHO_MAX) cho_new = cho_rd + CHO_W'(1);
      end
   end

   assign lh_new   = H'({lh_rd, taken_ff});
   assign sweeping = (state_ff == ST_SWEEP);
   assign upd_go   = (state_ff == ST_UPD) && (!rsp_valid_ff || rsp_ready);
   assign item_pop = (state_ff == ST_IDLE) && item_valid;

   // tables
   tbp_ram #(.WIDTH(CB), .DEPTH(1 << P)) u_gsh (
      .clock(clock), .wr_en(sweeping || upd_go),
      .wr_addr(sweeping ? sweep_ff[P-1:0] : gsh_idx),
      .wr_data(sweeping ? CNT_INIT : gsh_new),
      .rd_addr(gsh_idx), .rd_data(gsh_rd));

   tbp_ram #(.WIDTH(CB), .DEPTH(1 << P)) u_lcnt (
      .clock(clock), .wr_en(sweeping || upd_go),
      .wr_addr(sweeping ? sweep_ff[P-1:0] : lc_idx),
      .wr_data(sweeping ? CNT_INIT : lc_new),
      .rd_addr(lc_idx), .rd_data(lc_rd));

   tbp_ram #(.WIDTH(H), .DEPTH(1 << L)) u_lhist (
      .clock(clock), .wr_en(sweeping || upd_go),
      .wr_addr(sweeping ? sweep_ff[L-1:0] : lh_idx),
      .wr_data(sweeping ? '0 : lh_new),
      .rd_addr(lh_idx), .rd_data(lh_rd));

   tbp_ram #(.WIDTH(CHO_W), .DEPTH(1 << C)) u_cho (
      .clock(clock), .wr_en(sweeping || upd_go),
      .wr_addr(sweeping ? sweep_ff[C-1:0] : cho_idx),
      .wr_data(sweeping ? CHO_INIT : cho_new),
      .rd_addr(cho_idx), .rd_data(cho_rd));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      ghist_in     = ghist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_SWEEP: begin
            sweep_in = sweep_ff + SW'(1);
            if (sweep_ff == {SW{1'b1}}) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (item_valid) state_in = ST_HIST;
         end
         ST_HIST: state_in = ST_LCNT;
         ST_LCNT: state_in = ST_UPD;
         ST_UPD: begin
            if (upd_go) begin
               ghist_in     = H'({ghist_ff, taken_ff});
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         ghist_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         ghist_ff     <= ghist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // held branch and result payload
   always_ff @(posedge clock) begin
      if (item_pop) begin
         addr_ff  <= item.branch_address;
         taken_ff <= item.taken;
      end
      if (upd_go) begin
         pred_ff  <= pred;
         local_ff <= use_local;
         corr_ff  <= (pred == taken_ff);
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_predicted_taken    = pred_ff;
   assign rsp_chose_local        = local_ff;
   assign rsp_prediction_correct = corr_ff;

endmodule

// ----- rtl/tournament_branch_predictor_unit.sv -----
// top level of the tournament branch predictor
//
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_ready  branch_address[31:0], taken
//  rsp_      out        rsp_valid/rsp_ready  predicted_taken, chose_local,
//                                            prediction_correct
//
// each branch steps through the back end: local history read, local counter
// read (its index depends on that history), then an update state writing all tables.
// after reset a clearing pass over 2^max(PATTERN_INDEX_BITS, CHOOSER_INDEX_BITS,
// LOCAL_TABLE_BITS) entries initializes the tables; the queue still takes two items.
// a two entry queue lets req_ take items while the back end works or rsp_ stalls.
module tournament_branch_predictor_unit
   import tbp_pkg::*;
#(
   parameter int PATTERN_INDEX_BITS = 12,
   parameter int HISTORY_BITS       = 2,
   parameter int LOCAL_TABLE_BITS   = 6,
   parameter int COUNTER_BITS       = 2,
   parameter int CHOOSER_INDEX_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_branch_address,
   input  logic        req_taken,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_predicted_taken,
   output logic        rsp_chose_local,
   output logic        rsp_prediction_correct
);

   tbp_item_type item;
   logic         item_valid, item_pop;

   // queue in front of the table sequencer
   tbp_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_branch_address(req_branch_address), .req_taken(req_taken),
      .item_valid(item_valid), .item(item), .item_pop(item_pop));

   tbp_back #(
      .PATTERN_INDEX_BITS(PATTERN_INDEX_BITS), .HISTORY_BITS(HISTORY_BITS),
      .LOCAL_TABLE_BITS(LOCAL_TABLE_BITS), .COUNTER_BITS(COUNTER_BITS),
      .CHOOSER_INDEX_BITS(CHOOSER_INDEX_BITS)
   ) u_back (
      .clock(clock), .reset(reset),
      .item_valid(item_valid), .item(item), .item_pop(item_pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_predicted_taken(rsp_predicted_taken),
      .rsp_chose_local(rsp_chose_local),
      .rsp_prediction_correct(rsp_prediction_correct));

endmodule
